// File: hw/rtl/brfr_pkg.sv
// Shared types and constants for the base range frequency ranker.
// No dependencies.
`timescale 1ns / 1ps

package brfr_pkg;

  localparam int MAX_LEN = 65536;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int POS_W   = 17;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int ROW_W   = 4 * CNT_W;

  typedef logic [3:0][CNT_W-1:0] cnt_row_t;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_LEFT,
    ST_DIFF,
    ST_SORT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic do_append;
    logic do_clear;
    logic rd_right;
    logic rd_left;
    logic cap_hi;
    logic cap_diff;
    logic clr_cnt;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    err;
    logic    full;
  } status_t;

endpackage

// File: hw/rtl/brfr_ram.sv
// Generic single write, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/brfr_ctrl.sv
// Controller state machine: sequences append, clear and query items.
// Depends on brfr_pkg.
`timescale 1ns / 1ps

module brfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  brfr_pkg::status_t status_i,
  output brfr_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import brfr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.action)
          ACT_QUERY: state_d = status_i.err ? ST_SORT : ST_RD_LEFT;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_RD_LEFT: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_SORT;
      ST_SORT:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = start_i;
      end
      ST_EXEC: begin
        case (status_i.action)
          ACT_APPEND: cmd_o.do_append = !status_i.full;
          ACT_CLEAR:  cmd_o.do_clear  = 1'b1;
          ACT_QUERY: begin
            cmd_o.clr_cnt  = status_i.err;
            cmd_o.rd_right = !status_i.err;
          end
          default: ;
        endcase
      end
      ST_RD_LEFT: begin
        cmd_o.cap_hi  = 1'b1;
        cmd_o.rd_left = 1'b1;
      end
      ST_DIFF: begin
        cmd_o.cap_diff = 1'b1;
      end
      ST_SORT: begin
        cmd_o.load_res = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/brfr_dpath.sv
// Datapath: running counts, prefix count RAM, range difference and ranking.
// Depends on brfr_pkg and brfr_ram.
`timescale 1ns / 1ps

module brfr_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  brfr_pkg::cmd_t          cmd_i,
  output brfr_pkg::status_t       status_o,
  input  logic [1:0]              action_i,
  input  logic [1:0]              base_code_i,
  input  logic [brfr_pkg::POS_W-1:0] range_left_i,
  input  logic [brfr_pkg::POS_W-1:0] range_right_i,
  output logic                    result_valid_o,
  output logic [1:0]              rank_first_o,
  output logic [1:0]              rank_second_o,
  output logic [1:0]              rank_third_o,
  output logic [1:0]              rank_fourth_o,
  output logic                    range_error_o
);
  import brfr_pkg::*;

  logic [1:0]       action_q, base_q;
  logic [POS_W-1:0] left_q, right_q;
  logic [CNT_W-1:0] len_q, len_d;
  cnt_row_t         run_q, run_d;
  cnt_row_t         hi_q, cnt_q, lo_row;
  logic             left_one_q;
  logic             err;
  logic             res_valid_q;
  logic [3:0][1:0]  rank_q, rank_d;
  logic             res_err_q;

  logic             ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q   <= action_i;
      base_q     <= base_code_i;
      left_q     <= range_left_i;
      right_q    <= range_right_i;
      left_one_q <= (range_left_i == POS_W'(1));
    end
    if (cmd_i.cap_hi) begin
      hi_q <= ram_rdata;
    end
    if (cmd_i.clr_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.cap_diff) begin
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= hi_q[i] - lo_row[i];
      end
    end
    if (cmd_i.load_res) begin
      rank_q    <= rank_d;
      res_err_q <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      run_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      if (cmd_i.do_append || cmd_i.do_clear) run_q <= run_d;
      res_valid_q <= cmd_i.load_res;
    end
  end

  always_comb begin
    run_d = run_q;
    len_d = len_q;
    if (cmd_i.do_clear) begin
      run_d = '0;
      len_d = '0;
    end else if (cmd_i.do_append) begin
      run_d[base_q] = run_q[base_q] + CNT_W'(1);
      len_d = len_q + CNT_W'(1);
    end
  end

  assign err = (left_q == '0) || (left_q > right_q) ||
               (CMP_W'(right_q) > CMP_W'(len_q));

  assign ram_re    = cmd_i.rd_right || cmd_i.rd_left;
  assign ram_raddr = cmd_i.rd_left ? ADDR_W'(left_q - POS_W'(2))
                                   : ADDR_W'(right_q - POS_W'(1));

  brfr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_append),
    .waddr_i (ADDR_W'(len_q)),
    .wdata_i (run_d),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign lo_row = left_one_q ? cnt_row_t'('0) : cnt_row_t'(ram_rdata);

  // position of each base = number of bases ranked ahead of it
  always_comb begin
    logic [1:0] pos;
    rank_d = '0;
    for (int i = 0; i < 4; i++) begin
      pos = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j < i && cnt_q[j] >= cnt_q[i]) pos = pos + 2'd1;
        if (j > i && cnt_q[j] > cnt_q[i])  pos = pos + 2'd1;
      end
      rank_d[pos] = 2'(i);
    end
  end

  assign status_o.action = action_e'(action_q);
  assign status_o.err    = err;
  assign status_o.full   = (CMP_W'(len_q) >= CMP_W'(MAX_LEN));

  assign result_valid_o = res_valid_q;
  assign rank_first_o   = rank_q[0];
  assign rank_second_o  = rank_q[1];
  assign rank_third_o   = rank_q[2];
  assign rank_fourth_o  = rank_q[3];
  assign range_error_o  = res_err_q;

endmodule

// File: hw/rtl/base_range_frequency_ranker_top.sv
// Top level of the base range frequency ranker.
// Depends on brfr_pkg, brfr_ctrl and brfr_dpath.
// Append and clear items run in EXEC; the next item may start once busy falls.
// A valid query steps through EXEC, RD_LEFT, DIFF and SORT; an out-of-range one
// goes from EXEC to SORT. The result pulses once SORT has registered it. The
// single read port of the prefix count RAM is read once for each bound.
// Reset clears length, running counts and control; the RAM holds no reset value.
`timescale 1ns / 1ps

module base_range_frequency_ranker_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action_i,
  input  logic [1:0]                 base_code_i,
  input  logic [brfr_pkg::POS_W-1:0] range_left_i,
  input  logic [brfr_pkg::POS_W-1:0] range_right_i,
  output logic                       result_valid_o,
  output logic [1:0]                 rank_first_o,
  output logic [1:0]                 rank_second_o,
  output logic [1:0]                 rank_third_o,
  output logic [1:0]                 rank_fourth_o,
  output logic                       range_error_o
);
  import brfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  brfr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  brfr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .base_code_i    (base_code_i),
    .range_left_i   (range_left_i),
    .range_right_i  (range_right_i),
    .result_valid_o (result_valid_o),
    .rank_first_o   (rank_first_o),
    .rank_second_o  (rank_second_o),
    .rank_third_o   (rank_third_o),
    .rank_fourth_o  (rank_fourth_o),
    .range_error_o  (range_error_o)
  );

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  a_err_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |->
      (rank_first_o == 2'd0 && rank_second_o == 2'd1 &&
       rank_third_o == 2'd2 && rank_fourth_o == 2'd3))
    else $error("error result not in code order");

endmodule
